FILE: sv/pupt_pkg.sv
// Shared types and constants for the per-user policy table.
`default_nettype none
package pupt_pkg;

    localparam int TABLE_ENTRIES = 128;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 88;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_WRITE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_MAX_MCS           = 3'd0,
        REG_MIN_GRANT_PRB     = 3'd1,
        REG_SCHED_MUL         = 3'd2,
        REG_MAXCG_OVERRIDE    = 3'd3,
        REG_SMALL_BURST_BYTES = 3'd4,
        REG_SMALL_BURST_MUL   = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [15:0] key;
        logic [5:0]  mcs;
        logic [9:0]  prb;
        logic [15:0] smul;
        logic [16:0] cg;
        logic [24:0] bytes;
        logic [15:0] bmul;
    } t_item;

    typedef struct packed {
        logic [15:0] key;
        logic [5:0]  mcs;
        logic [9:0]  prb;
        logic [15:0] smul;
        logic [16:0] cg;
        logic [24:0] bytes;
        logic [15:0] bmul;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [4:0]  mcs;
        logic [8:0]  prb;
        logic [15:0] smul;
        logic [15:0] cg;
        logic [23:0] bytes;
        logic [15:0] bmul;
    } t_cfg;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [4:0]  mcs;
        logic [8:0]  prb;
        logic [15:0] smul;
        logic [15:0] cg;
        logic [23:0] bytes;
        logic [15:0] bmul;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/pupt_ram.sv
// Entry memory: one write port, one read port with registered read data.
`default_nettype none
module pupt_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [pupt_pkg::IDX_W-1:0]  i_waddr,
    input  wire pupt_pkg::t_entry            i_wdata,
    input  wire logic [pupt_pkg::IDX_W-1:0]  i_raddr,
    output pupt_pkg::t_entry                 o_rdata
);
    import pupt_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: sv/pupt_cfg.sv
// Default-value registers written through the configuration channel.
`default_nettype none
module pupt_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr,
    input  wire logic [pupt_pkg::CFG_IDX_W-1:0]    i_index,
    input  wire logic [pupt_pkg::CFG_DATA_W-1:0]   i_data,
    output pupt_pkg::t_cfg                         o_cfg
);
    import pupt_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mcs   <= '0;
            r_cfg.prb   <= '0;
            r_cfg.smul  <= 16'd256;
            r_cfg.cg    <= '0;
            r_cfg.bytes <= '0;
            r_cfg.bmul  <= 16'd256;
        end else if (i_wr) begin
            case (i_index)
                REG_MAX_MCS:           r_cfg.mcs   <= i_data[4:0];
                REG_MIN_GRANT_PRB:     r_cfg.prb   <= i_data[8:0];
                REG_SCHED_MUL:         r_cfg.smul  <= i_data[15:0];
                REG_MAXCG_OVERRIDE:    r_cfg.cg    <= i_data[15:0];
                REG_SMALL_BURST_BYTES: r_cfg.bytes <= i_data[23:0];
                REG_SMALL_BURST_MUL:   r_cfg.bmul  <= i_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

FILE: sv/pupt_engine.sv
// Table engine: scans the entry memory on write and lookup, then commits a write or clear, or builds a lookup result.
`default_nettype none
module pupt_engine (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    output logic                   o_item_ready,
    input  wire pupt_pkg::t_item   i_item,
    input  wire pupt_pkg::t_cfg    i_cfg,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output pupt_pkg::t_result      o_res
);
    import pupt_pkg::*;

    t_state                   r_state, n_state;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_chk_vld;
    logic [IDX_W-1:0]         r_chk_idx;
    logic                     r_hit, r_free;
    logic [IDX_W-1:0]         r_hit_idx, r_free_idx;
    t_entry                   r_hit_ent;
    t_item                    r_item;
    t_result                  r_res, n_res;

    t_entry           rd_ent, mem_wdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    logic             accept, issue, scan_last, chk_match, chk_free, commit;

    pupt_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_ent)
    );

    // scan: address issued from r_cnt, compared in the next cycle on r_chk_idx
    assign accept    = i_item_valid && o_item_ready;
    assign issue     = (r_state == ST_SCAN) && (r_cnt < CNT_W'(TABLE_ENTRIES));
    assign mem_raddr = r_cnt[IDX_W-1:0];
    assign scan_last = r_chk_vld && (r_chk_idx == IDX_W'(TABLE_ENTRIES - 1));
    assign chk_match = r_chk_vld && r_valid[r_chk_idx] && (rd_ent.key == r_item.key);
    assign chk_free  = r_chk_vld && !r_valid[r_chk_idx];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.op == OP_WRITE || i_item.op == OP_LOOKUP) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_COMMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: n_state = ST_DONE;
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_item_ready = (r_state == ST_IDLE);
        o_res_valid  = (r_state == ST_DONE);
        commit       = (r_state == ST_COMMIT);
        mem_we       = commit && (r_item.op == OP_WRITE) && (r_hit || r_free);
        mem_waddr    = r_hit ? r_hit_idx : r_free_idx;
    end

    always_comb begin
        mem_wdata.key   = r_item.key;
        mem_wdata.mcs   = r_item.mcs;
        mem_wdata.prb   = r_item.prb;
        mem_wdata.smul  = r_item.smul;
        mem_wdata.cg    = r_item.cg;
        mem_wdata.bytes = r_item.bytes;
        mem_wdata.bmul  = r_item.bmul;
    end

    // result: defaults where the key is absent or the stored field is unset
    always_comb begin
        n_res = '0;
        case (r_item.op)
            OP_WRITE: n_res.status = !(r_hit || r_free);
            OP_LOOKUP: begin
                n_res.found = r_hit;
                n_res.mcs   = i_cfg.mcs;
                n_res.prb   = i_cfg.prb;
                n_res.smul  = i_cfg.smul;
                n_res.cg    = i_cfg.cg;
                n_res.bytes = i_cfg.bytes;
                n_res.bmul  = i_cfg.bmul;
                if (r_hit) begin
                    if (!r_hit_ent.mcs[5]) begin
                        n_res.mcs = r_hit_ent.mcs[4:0];
                    end
                    if (!r_hit_ent.prb[9]) begin
                        n_res.prb = r_hit_ent.prb[8:0];
                    end
                    if (!r_hit_ent.smul[15] && (r_hit_ent.smul != '0)) begin
                        n_res.smul = r_hit_ent.smul;
                    end
                    if (!r_hit_ent.cg[16] && (r_hit_ent.cg != '0)) begin
                        n_res.cg = r_hit_ent.cg[15:0];
                    end
                    if (!r_hit_ent.bytes[24] && (r_hit_ent.bytes != '0)) begin
                        n_res.bytes = r_hit_ent.bytes[23:0];
                    end
                    if (!r_hit_ent.bmul[15] && (r_hit_ent.bmul != '0)) begin
                        n_res.bmul = r_hit_ent.bmul;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_cnt     <= '0;
            r_chk_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= issue;
            if (accept) begin
                r_cnt  <= '0;
                r_hit  <= 1'b0;
                r_free <= 1'b0;
            end else begin
                if (issue) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                if (chk_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (chk_free && !r_free) begin
                    r_free <= 1'b1;
                end
            end
            if (commit && r_item.op == OP_CLEAR) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= mem_raddr;
        if (accept) begin
            r_item <= i_item;
        end
        if (chk_match && !r_hit) begin
            r_hit_idx <= r_chk_idx;
            r_hit_ent <= rd_ent;
        end
        if (chk_free && !r_free) begin
            r_free_idx <= r_chk_idx;
        end
        if (commit) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

FILE: sv/per_user_policy_table.sv
// Top level of the per-user policy table: stream ports, config port and result register.
//
//   Channel   Direction  Handshake                      Content
//   s_axis    in         s_axis_tvalid / s_axis_tready  operation and entry fields
//   m_axis    out        m_axis_tvalid / m_axis_tready  status, found and effective fields
//   cfg       in         i_cfg_valid / o_cfg_ready      register index and default value
//
// Write and lookup scan the keys with one entry memory read per cycle, then pass through a
// commit state before the result is ready. Clear and the unused code skip the scan and go
// straight to commit. Reset empties the table at once.
// One item is worked at a time; the next is accepted while a result waits in the output
// register, and the engine holds a finished result until that register frees up.
`default_nettype none
module per_user_policy_table (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // key[15:0], wr_max_mcs[21:16], wr_min_grant_prb[31:22], wr_sched_mul[47:32],
    // wr_maxcg_override[64:48], wr_small_burst_bytes[89:65], wr_small_burst_mul[105:90]
    input  wire logic [pupt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation[1:0]
    input  wire logic [pupt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // rd_max_mcs[4:0], rd_min_grant_prb[13:5], rd_sched_mul[29:14],
    // rd_maxcg_override[45:30], rd_small_burst_bytes[69:46], rd_small_burst_mul[85:70]
    output logic [pupt_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    // status[0], found[1]
    output logic [pupt_pkg::OUT_TUSER_W-1:0]         m_axis_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pupt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pupt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pupt_pkg::*;

    t_item   item;
    t_cfg    cfg;
    t_result res;
    logic    res_valid, res_ready;
    logic    r_out_valid;
    t_result r_out;

    always_comb begin
        item.op    = t_op'(s_axis_tuser[1:0]);
        item.key   = s_axis_tdata[15:0];
        item.mcs   = s_axis_tdata[21:16];
        item.prb   = s_axis_tdata[31:22];
        item.smul  = s_axis_tdata[47:32];
        item.cg    = s_axis_tdata[64:48];
        item.bytes = s_axis_tdata[89:65];
        item.bmul  = s_axis_tdata[105:90];
    end

    assign o_cfg_ready = 1'b1;

    pupt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    pupt_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (s_axis_tvalid),
        .o_item_ready (s_axis_tready),
        .i_item       (item),
        .i_cfg        (cfg),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // load the output register when empty or draining this cycle
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.found, r_out.status};
    assign m_axis_tdata  = {2'b00, r_out.bmul, r_out.bytes, r_out.cg,
                            r_out.smul, r_out.prb, r_out.mcs};

endmodule
`default_nettype wire

FILE: bench/per_user_policy_table_test.sv
// Self-checking bench for the per-user policy table: directed cases, full table, random traffic.
`default_nettype none
module per_user_policy_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pupt_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int END_SETTLE     = 200;
    localparam int RECENT_KEYS    = 16;

    // Register indexes past the last register; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                    i_clk;
    logic                    i_rst_n       = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]   s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    per_user_policy_table i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Shadow of the table and the default registers.
    bit          slot_used [TABLE_ENTRIES];
    t_entry      slot_entry[TABLE_ENTRIES];
    t_cfg        defaults_shadow;
    t_result     policy_replies_due[$];
    logic [15:0] recent_keys[$];

    bit idle_on     = 1'b1;
    bit rx_hold_req = 1'b0;
    int fail_count  = 0;
    int n_items     = 0;
    int n_replies   = 0;
    int n_drops     = 0;
    int n_hits      = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int find_slot(logic [15:0] key);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i] && slot_entry[i].key == key) return i;
        end
        return -1;
    endfunction

    // Update the shadow table with one operation and return the reply it must produce.
    function automatic t_result apply_policy_op(t_item it);
        t_result r;
        t_entry  e;
        int      slot;
        r    = '0;
        slot = -1;
        case (it.op)
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
            end
            OP_WRITE: begin
                recent_keys.push_back(it.key);
                if (recent_keys.size() > RECENT_KEYS) void'(recent_keys.pop_front());
                slot = find_slot(it.key);
                for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
                    if (!slot_used[i]) slot = i;
                end
                if (slot < 0) begin
                    r.status = 1'b1;
                    n_drops++;
                end else begin
                    slot_used[slot]  = 1'b1;
                    slot_entry[slot] = '{key: it.key, mcs: it.mcs, prb: it.prb, smul: it.smul,
                                         cg: it.cg, bytes: it.bytes, bmul: it.bmul};
                end
            end
            OP_LOOKUP: begin
                r.mcs   = defaults_shadow.mcs;
                r.prb   = defaults_shadow.prb;
                r.smul  = defaults_shadow.smul;
                r.cg    = defaults_shadow.cg;
                r.bytes = defaults_shadow.bytes;
                r.bmul  = defaults_shadow.bmul;
                slot = find_slot(it.key);
                if (slot >= 0) begin
                    e       = slot_entry[slot];
                    r.found = 1'b1;
                    n_hits++;
                    // mcs and prb count zero as set; the rest need a positive value
                    if (!e.mcs[5])             r.mcs   = e.mcs[4:0];
                    if (!e.prb[9])             r.prb   = e.prb[8:0];
                    if ($signed(e.cg) > 0)     r.cg    = e.cg[15:0];
                    if ($signed(e.bytes) > 0)  r.bytes = e.bytes[23:0];
                    if ($signed(e.smul) > 0)   r.smul  = e.smul;
                    if ($signed(e.bmul) > 0)   r.bmul  = e.bmul;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Value in -1..max_val, two's complement, weighted toward the edges.
    function automatic logic [24:0] pick_field(int unsigned max_val);
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return 25'(max_val);
            default: return 25'($urandom_range(0, max_val));
        endcase
    endfunction

    function automatic logic [15:0] pick_q88();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_item rand_item(t_op op, logic [15:0] key);
        t_item it;
        it.op    = op;
        it.key   = key;
        it.mcs   = 6'(pick_field(31));
        it.prb   = 10'(pick_field(511));
        it.smul  = pick_q88();
        it.cg    = 17'(pick_field(65535));
        it.bytes = pick_field(16777215);
        it.bmul  = pick_q88();
        return it;
    endfunction

    function automatic t_item make_item(t_op op, logic [15:0] key, logic [5:0] mcs,
                                        logic [9:0] prb, logic [15:0] smul, logic [16:0] cg,
                                        logic [24:0] bytes, logic [15:0] bmul);
        return '{op: op, key: key, mcs: mcs, prb: prb, smul: smul, cg: cg, bytes: bytes,
                 bmul: bmul};
    endfunction

    function automatic t_cfg rand_cfg();
        t_cfg c;
        if ($urandom_range(0, 3) == 0) begin
            c = '1;
            c.smul = 16'h7FFF;
            c.bmul = 16'h7FFF;
        end else begin
            c.mcs   = 5'($urandom);
            c.prb   = 9'($urandom);
            c.smul  = pick_q88();
            c.cg    = 16'($urandom);
            c.bytes = 24'($urandom);
            c.bmul  = pick_q88();
        end
        return c;
    endfunction

    // Offer one item and hold it until the transaction completes.
    task automatic push_item(t_item it);
        int gap;
        if (idle_on && $urandom_range(0, 9) < 3) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        policy_replies_due.push_back(apply_policy_op(it));
        n_items++;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {6'd0, it.bmul, it.bytes, it.cg, it.smul, it.prb, it.mcs, it.key};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (policy_replies_due.size() != 0);
    endtask

    // Leaves i_cfg_valid high; the caller drops it after its last write.
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MAX_MCS:           defaults_shadow.mcs   = val[4:0];
            REG_MIN_GRANT_PRB:     defaults_shadow.prb   = val[8:0];
            REG_SCHED_MUL:         defaults_shadow.smul  = val[15:0];
            REG_MAXCG_OVERRIDE:    defaults_shadow.cg    = val[15:0];
            REG_SMALL_BURST_BYTES: defaults_shadow.bytes = val[23:0];
            REG_SMALL_BURST_MUL:   defaults_shadow.bmul  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_defaults(t_cfg c);
        wait_drained();
        set_reg(REG_MAX_MCS, 24'(c.mcs));
        set_reg(REG_MIN_GRANT_PRB, 24'(c.prb));
        set_reg(REG_SCHED_MUL, 24'(c.smul));
        set_reg(REG_MAXCG_OVERRIDE, 24'(c.cg));
        set_reg(REG_SMALL_BURST_BYTES, c.bytes);
        set_reg(REG_SMALL_BURST_MUL, 24'(c.bmul));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_lookups();
        push_item(rand_item(OP_LOOKUP, 16'h0000));
        push_item(rand_item(OP_LOOKUP, 16'hFFFF));
    endtask

    task automatic test_write_lookup();
        load_defaults('{mcs: 5'd17, prb: 9'd300, smul: 16'h0180, cg: 16'd1234,
                        bytes: 24'h0ABCDE, bmul: 16'hFF00});
        push_item(make_item(OP_WRITE, 16'hFFFF, 6'd31, 10'd511, 16'h7FFF, 17'h0FFFF,
                            25'h0FFFFFF, 16'h7FFF));
        push_item(rand_item(OP_LOOKUP, 16'hFFFF));
        push_item(make_item(OP_WRITE, 16'h0000, '1, '1, 16'h0000, '1, '1, 16'h0000));
        push_item(rand_item(OP_LOOKUP, 16'h0000));
        // zero is a real value for mcs and prb, but unset for the others
        push_item(make_item(OP_WRITE, 16'h0001, 6'd0, 10'd0, 16'h8000, 17'd0, 25'd0,
                            16'hFFFF));
        push_item(rand_item(OP_LOOKUP, 16'h0001));
        push_item(make_item(OP_WRITE, 16'h0002, '1, '1, 16'h0001, 17'd1, 25'd1, 16'h0001));
        push_item(rand_item(OP_LOOKUP, 16'h0002));
        push_item(rand_item(OP_LOOKUP, 16'h1234));
    endtask

    task automatic test_overwrite();
        // unset fields in a rewrite replace the stored values too
        push_item(make_item(OP_WRITE, 16'hFFFF, '1, '1, 16'h0000, '1, '1, 16'h8000));
        push_item(rand_item(OP_LOOKUP, 16'hFFFF));
        push_item(make_item(OP_WRITE, 16'hFFFF, 6'd10, 10'd100, 16'h0040, 17'd77,
                            25'd4096, 16'h0200));
        push_item(rand_item(OP_LOOKUP, 16'hFFFF));
    endtask

    task automatic test_unused_op();
        push_item(make_item(OP_NONE, 16'hFFFF, '1, '1, '1, '1, '1, '1));
        push_item(rand_item(OP_LOOKUP, 16'hFFFF));
    endtask

    task automatic test_clear();
        push_item(rand_item(OP_CLEAR, 16'hFFFF));
        push_item(rand_item(OP_LOOKUP, 16'hFFFF));
        push_item(rand_item(OP_LOOKUP, 16'h0001));
    endtask

    task automatic test_config_registers();
        load_defaults('{mcs: 5'd31, prb: 9'd511, smul: 16'h7FFF, cg: 16'hFFFF,
                        bytes: 24'hFFFFFF, bmul: 16'h7FFF});
        push_item(rand_item(OP_LOOKUP, 16'($urandom)));
        load_defaults('{mcs: 5'd0, prb: 9'd0, smul: 16'h8000, cg: 16'd0, bytes: 24'd0,
                        bmul: 16'h8000});
        push_item(rand_item(OP_LOOKUP, 16'($urandom)));
        wait_drained();
        set_reg(REG_SPARE_LO, 24'hFFFFFF);
        set_reg(REG_SPARE_HI, 24'($urandom));
        i_cfg_valid <= 1'b0;
        push_item(rand_item(OP_LOOKUP, 16'($urandom)));
    endtask

    task automatic test_table_full();
        logic [15:0] base;
        base = 16'($urandom);
        push_item(rand_item(OP_CLEAR, base));
        for (int i = 0; i < TABLE_ENTRIES; i++) push_item(rand_item(OP_WRITE, base + 16'(i)));
        push_item(rand_item(OP_WRITE, base + 16'd200));
        push_item(rand_item(OP_LOOKUP, base + 16'd200));
        // an existing key can still be rewritten when no slot is free
        push_item(rand_item(OP_WRITE, base + 16'd5));
        push_item(rand_item(OP_LOOKUP, base + 16'd5));
        push_item(rand_item(OP_CLEAR, base));
        push_item(rand_item(OP_WRITE, base + 16'd200));
        push_item(rand_item(OP_LOOKUP, base + 16'd200));
    endtask

    task automatic test_output_backpressure();
        bit saved;
        saved       = idle_on;
        idle_on     = 1'b0;
        rx_hold_req = 1'b1;
        for (int k = 0; k < 6; k++) begin
            push_item(rand_item(k[0] ? OP_LOOKUP : OP_WRITE, 16'($urandom_range(0, 3))));
        end
        wait_drained();
        idle_on = saved;
    endtask

    task automatic run_random(int count, int span, bit seq_keys, int clear_pct);
        logic [15:0] base;
        logic [15:0] key;
        t_op         op;
        int          r;
        int          seq;
        base = 16'($urandom);
        seq  = 0;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < clear_pct)           op = OP_CLEAR;
            else if (r < clear_pct + 3)  op = OP_NONE;
            else if (r < clear_pct + 60) op = OP_WRITE;
            else                         op = OP_LOOKUP;
            if (recent_keys.size() != 0 && $urandom_range(0, 99) < 40) begin
                key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            end else if (seq_keys) begin
                key = base + 16'(seq % (span + 1));
                seq++;
            end else begin
                key = base + 16'($urandom_range(0, span));
            end
            push_item(rand_item(op, key));
        end
    endtask

    task automatic test_random_traffic();
        load_defaults(rand_cfg());
        run_random(150, 7, 1'b0, 3);
        // walk a key range wider than the table so it fills and drops writes
        load_defaults(rand_cfg());
        push_item(rand_item(OP_CLEAR, 16'h0000));
        run_random(250, 139, 1'b1, 0);
        load_defaults(rand_cfg());
        run_random(80, 65535, 1'b0, 2);
        load_defaults(rand_cfg());
        idle_on = 1'b0;
        run_random(100, 31, 1'b0, 3);
    endtask

    // Receiver: random stall bursts, plus one long hold on request.
    int rx_hold_left  = 0;
    int rx_burst_left = 0;
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req   = 1'b0;
            rx_hold_left  = RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left--;
        end else if (rx_burst_left != 0) begin
            rx_burst_left--;
        end else if (idle_on && $urandom_range(0, 2) == 0) begin
            m_axis_tready <= 1'b0;
            rx_burst_left = $urandom_range(0, 13);
        end else begin
            m_axis_tready <= 1'b1;
            rx_burst_left = idle_on ? $urandom_range(0, 20) : 0;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (policy_replies_due.size() == 0) begin
                $error("reply with no item outstanding: tuser 0x%0h tdata 0x%0h",
                       m_axis_tuser, m_axis_tdata);
                fail_count++;
            end else begin
                want = policy_replies_due.pop_front();
                n_replies++;
                check_field("status", 32'(want.status), 32'(m_axis_tuser[0]));
                check_field("found", 32'(want.found), 32'(m_axis_tuser[1]));
                check_field("rd_max_mcs", 32'(want.mcs), 32'(m_axis_tdata[4:0]));
                check_field("rd_min_grant_prb", 32'(want.prb), 32'(m_axis_tdata[13:5]));
                check_field("rd_sched_mul", 32'(want.smul), 32'(m_axis_tdata[29:14]));
                check_field("rd_maxcg_override", 32'(want.cg), 32'(m_axis_tdata[45:30]));
                check_field("rd_small_burst_bytes", 32'(want.bytes), 32'(m_axis_tdata[69:46]));
                check_field("rd_small_burst_mul", 32'(want.bmul), 32'(m_axis_tdata[85:70]));
            end
        end
    end

    // End the run if no transaction of any kind completes for too long.
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("per_user_policy_table_test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
        defaults_shadow      = '0;
        defaults_shadow.smul = 16'd256;
        defaults_shadow.bmul = 16'd256;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_lookups();
        test_write_lookup();
        test_overwrite();
        test_unused_op();
        test_clear();
        test_config_registers();
        test_table_full();
        test_output_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("run covered %0d items and %0d checked replies over clear, write, lookup",
                 n_items, n_replies);
        $display("and unused codes: %0d lookup hits, %0d writes dropped on a full table",
                 n_hits, n_drops);
        if (fail_count == 0) begin
            $display("per_user_policy_table_test passed");
        end else begin
            $display("per_user_policy_table_test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
